// File: rtl/drs_pkg.sv
// shared types and codes for the disjoint rectangle set engine
// no dependencies
`default_nettype none
package drs_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int COORD_BITS_DEF  = 16;

  localparam logic [2:0] FUNC_ADD   = 3'd0;
  localparam logic [2:0] FUNC_SUB   = 3'd1;
  localparam logic [2:0] FUNC_CLIP  = 3'd2;
  localparam logic [2:0] FUNC_UNION = 3'd3;
  localparam logic [2:0] FUNC_READ  = 3'd4;
  localparam logic [2:0] FUNC_CLEAR = 3'd5;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_OVF   = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [15:0] rect_x;
    logic signed [15:0] rect_y;
    logic [14:0]        rect_w;
    logic [14:0]        rect_h;
    logic [5:0]         entry_index;
  } drs_in_t;

  typedef struct packed {
    logic signed [15:0] res_x;
    logic signed [15:0] res_y;
    logic [15:0]        res_w;
    logic [15:0]        res_h;
    logic [6:0]         count;
    logic [1:0]         status;
  } drs_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK,
    ST_EX,
    ST_DROP,
    ST_MOVE,
    ST_APP,
    ST_PUSH,
    ST_POP,
    ST_POPD,
    ST_RDW,
    ST_DONE
  } drs_state_t;

endpackage
`default_nettype wire

// File: rtl/disjoint_rect_set_engine_unit.sv
// disjoint rectangle set engine: table of non-overlapping rectangles
// with add, subtract, clip, bounding box, read entry and clear
// depends on drs_pkg
// clear and read entry need no table walk; union, clip and subtract visit each entry,
//   add visits entries for each pending frame plus pushes and pops
// one item at a time; the walk over the table sets the pace
// an item is accepted while the previous result still waits in the output register
// reset (synchronous, rst_n low) empties the table and the pending stack
`default_nettype none
module disjoint_rect_set_engine_unit #(
  parameter int TABLE_DEPTH = drs_pkg::TABLE_DEPTH_DEF,
  parameter int COORD_BITS  = drs_pkg::COORD_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire drs_pkg::drs_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output drs_pkg::drs_out_t     out_data
);

  localparam int CB = COORD_BITS;
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int PD = 4 * TABLE_DEPTH;
  localparam int PW = $clog2(PD);
  localparam int SW = $clog2(PD + 1);
  localparam logic signed [17:0] CMAX18 = 18'((1 << (CB - 1)) - 1);
  localparam logic signed [CB-1:0] CMAX = CB'((1 << (CB - 1)) - 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic [SW-1:0] PDEPTH_C = SW'(PD);

  typedef struct packed {
    logic signed [CB-1:0] x1;
    logic signed [CB-1:0] y1;
    logic signed [CB-1:0] x2;
    logic signed [CB-1:0] y2;
  } box_t;

  typedef struct packed {
    box_t          rect;
    logic [CW-1:0] start;
  } frame_t;

  box_t   tbl [TABLE_DEPTH];
  frame_t pend [PD];

  drs_pkg::drs_state_t state_r, state_nxt;
  logic [2:0]    op_r, op_nxt;
  box_t          n_r, n_nxt;
  box_t          acc_r, acc_nxt;
  logic          hit_r, hit_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0] sd_r, sd_nxt;
  logic          ovf_r, ovf_nxt;
  box_t          pc_r [4];
  box_t          pc_nxt [4];
  logic [3:0]    pm_r, pm_nxt;
  logic [1:0]    k_r, k_nxt;
  logic          out_valid_r, out_valid_nxt;
  drs_pkg::drs_out_t out_data_r, out_data_nxt;

  // memory ports
  logic          t_re, t_we;
  logic [AW-1:0] t_ra, t_wa;
  box_t          t_wd, t_rq;
  logic          p_re, p_we;
  logic [PW-1:0] p_ra, p_wa;
  frame_t        p_wd, p_rq;

  always_ff @(posedge clk) begin
    if (t_we) tbl[t_wa] <= t_wd;
    if (t_re) t_rq <= tbl[t_ra];
  end

  always_ff @(posedge clk) begin
    if (p_we) pend[p_wa] <= p_wd;
    if (p_re) p_rq <= pend[p_ra];
  end

  // operand normalization: sign-extend, cut at the plane edge
  logic signed [CB-1:0] in_x, in_y;
  logic signed [17:0]   sum_x, sum_y;
  box_t                 in_box;
  logic                 in_empty;
  always_comb begin
    in_x  = in_data.rect_x[CB-1:0];
    in_y  = in_data.rect_y[CB-1:0];
    sum_x = 18'(in_x) + $signed({3'b000, in_data.rect_w});
    sum_y = 18'(in_y) + $signed({3'b000, in_data.rect_h});
    in_box.x1 = in_x;
    in_box.y1 = in_y;
    in_box.x2 = (sum_x > CMAX18) ? CMAX : sum_x[CB-1:0];
    in_box.y2 = (sum_y > CMAX18) ? CMAX : sum_y[CB-1:0];
    in_empty = (in_box.x2 <= in_box.x1) || (in_box.y2 <= in_box.y1);
  end

  logic accept;
  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != drs_pkg::ST_IDLE);

  // entry index widened so it compares against the count at any depth
  logic [CW+6:0] idx_w;
  logic [CW+6:0] cnt_w;
  logic          idx_ok;
  assign idx_w  = (CW + 7)'(in_data.entry_index);
  assign cnt_w  = (CW + 7)'(cnt_r);
  assign idx_ok = idx_w < cnt_w;

  // relation of the working rectangle to the entry just read
  box_t p, n;
  logic ov, enclosed, covers, hspan, vspan, trim_t, trim_b, trim_l, trim_r, trim;
  logic signed [CB-1:0] y0, y1, ix1, iy1, ix2, iy2;
  logic clip_empty;
  assign p = t_rq;
  assign n = n_r;
  always_comb begin
    ov       = !(n.x1 >= p.x2 || n.x2 <= p.x1 || n.y1 >= p.y2 || n.y2 <= p.y1);
    enclosed = n.x1 >= p.x1 && n.x2 <= p.x2 && n.y1 >= p.y1 && n.y2 <= p.y2;
    hspan  = n.x1 <= p.x1 && n.x2 >= p.x2;
    vspan  = n.y1 <= p.y1 && n.y2 >= p.y2;
    covers = hspan && vspan;
    trim_t = hspan && n.y1 <= p.y1 && n.y2 > p.y1;
    trim_b = hspan && !trim_t && n.y1 < p.y2 && n.y2 >= p.y2;
    trim_l = !hspan && vspan && n.x1 <= p.x1 && n.x2 > p.x1;
    trim_r = !hspan && vspan && !trim_l && n.x1 < p.x2 && n.x2 >= p.x2;
    trim   = trim_t || trim_b || trim_l || trim_r;
    y0  = (n.y1 > p.y1) ? n.y1 : p.y1;
    y1  = (n.y2 < p.y2) ? n.y2 : p.y2;
    ix1 = (n.x1 > p.x1) ? n.x1 : p.x1;
    iy1 = y0;
    ix2 = (n.x2 < p.x2) ? n.x2 : p.x2;
    iy2 = y1;
    clip_empty = (ix2 <= ix1) || (iy2 <= iy1);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      drs_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_data.func) inside
            drs_pkg::FUNC_ADD, drs_pkg::FUNC_SUB:
              state_nxt = in_empty ? drs_pkg::ST_DONE : drs_pkg::ST_CHK;
            drs_pkg::FUNC_CLIP, drs_pkg::FUNC_UNION: state_nxt = drs_pkg::ST_CHK;
            drs_pkg::FUNC_READ: state_nxt = drs_pkg::ST_RDW;
            default: state_nxt = drs_pkg::ST_DONE;
          endcase
        end
      end
      drs_pkg::ST_CHK: begin
        if (i_r >= cnt_r) begin
          state_nxt = (op_r == drs_pkg::FUNC_ADD) ? drs_pkg::ST_POP : drs_pkg::ST_DONE;
        end else begin
          state_nxt = drs_pkg::ST_EX;
        end
      end
      drs_pkg::ST_EX: begin
        case (op_r)
          drs_pkg::FUNC_ADD: begin
            // enclosed and covering entries take precedence over edge trims
            if (!ov) state_nxt = drs_pkg::ST_CHK;
            else if (enclosed) state_nxt = drs_pkg::ST_POP;
            else if (covers) state_nxt = drs_pkg::ST_DROP;
            else if (trim) state_nxt = drs_pkg::ST_CHK;
            else state_nxt = drs_pkg::ST_PUSH;
          end
          drs_pkg::FUNC_SUB: state_nxt = ov ? drs_pkg::ST_APP : drs_pkg::ST_CHK;
          drs_pkg::FUNC_CLIP: state_nxt = clip_empty ? drs_pkg::ST_DROP : drs_pkg::ST_CHK;
          default: state_nxt = drs_pkg::ST_CHK;
        endcase
      end
      drs_pkg::ST_DROP:
        state_nxt = (i_r == cnt_r - 1'b1) ? drs_pkg::ST_CHK : drs_pkg::ST_MOVE;
      drs_pkg::ST_MOVE: state_nxt = drs_pkg::ST_CHK;
      drs_pkg::ST_APP:  if (k_r == 2'd3) state_nxt = drs_pkg::ST_DROP;
      drs_pkg::ST_PUSH: if (k_r == 2'd3) state_nxt = drs_pkg::ST_POP;
      drs_pkg::ST_POP:
        state_nxt = (sd_r == '0) ? drs_pkg::ST_DONE : drs_pkg::ST_POPD;
      drs_pkg::ST_POPD: state_nxt = drs_pkg::ST_CHK;
      drs_pkg::ST_RDW:  state_nxt = drs_pkg::ST_DONE;
      drs_pkg::ST_DONE:
        if (!out_valid_r || !out_stall) state_nxt = drs_pkg::ST_IDLE;
      default: state_nxt = drs_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  logic signed [CB:0] dw, dh;
  always_comb begin
    op_nxt = op_r;
    n_nxt = n_r;
    acc_nxt = acc_r;
    hit_nxt = hit_r;
    i_nxt = i_r;
    cnt_nxt = cnt_r;
    sd_nxt = sd_r;
    ovf_nxt = ovf_r;
    pc_nxt = pc_r;
    pm_nxt = pm_r;
    k_nxt = k_r;
    out_data_nxt = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    t_re = 1'b0; t_ra = i_r[AW-1:0];
    t_we = 1'b0; t_wa = i_r[AW-1:0]; t_wd = p;
    p_re = 1'b0; p_ra = PW'(sd_r - 1'b1);
    p_we = 1'b0; p_wa = PW'(sd_r);
    p_wd.rect = pc_r[k_r];
    p_wd.start = i_r + 1'b1;
    dw = '0;
    dh = '0;
    unique case (state_r)
      drs_pkg::ST_IDLE: begin
        if (accept) begin
          op_nxt = in_data.func;
          n_nxt = in_box;
          i_nxt = '0;
          sd_nxt = '0;
          ovf_nxt = 1'b0;
          hit_nxt = 1'b0;
          if (in_data.func == drs_pkg::FUNC_CLEAR) cnt_nxt = '0;
          if (in_data.func == drs_pkg::FUNC_READ) begin
            hit_nxt = idx_ok;
            t_re = idx_ok;
            t_ra = AW'(idx_w);
          end
        end
      end
      drs_pkg::ST_CHK: begin
        if (i_r >= cnt_r) begin
          if (op_r == drs_pkg::FUNC_ADD) begin
            // nothing left overlaps: append
            if (cnt_r < DEPTH_C) begin
              t_we = 1'b1;
              t_wa = cnt_r[AW-1:0];
              t_wd = n_r;
              cnt_nxt = cnt_r + 1'b1;
            end else begin
              ovf_nxt = 1'b1;
            end
          end
        end else begin
          t_re = 1'b1;
        end
      end
      drs_pkg::ST_EX: begin
        k_nxt = '0;
        case (op_r)
          drs_pkg::FUNC_ADD: begin
            if (!ov) begin
              i_nxt = i_r + 1'b1;
            end else if (!enclosed && !covers && trim) begin
              t_we = 1'b1;
              t_wd = p;
              if (trim_t) t_wd.y1 = n.y2;
              if (trim_b) t_wd.y2 = n.y1;
              if (trim_l) t_wd.x1 = n.x2;
              if (trim_r) t_wd.x2 = n.x1;
              i_nxt = i_r + 1'b1;
            end
            // split pieces in push order: bottom, right, left, top
            pc_nxt[0] = '{x1: n.x1, y1: p.y2, x2: n.x2, y2: n.y2};
            pc_nxt[1] = '{x1: p.x2, y1: y0,   x2: n.x2, y2: y1};
            pc_nxt[2] = '{x1: n.x1, y1: y0,   x2: p.x1, y2: y1};
            pc_nxt[3] = '{x1: n.x1, y1: n.y1, x2: n.x2, y2: p.y1};
            pm_nxt = {n.y1 < p.y1, n.x1 < p.x1, n.x2 > p.x2, n.y2 > p.y2};
          end
          drs_pkg::FUNC_SUB: begin
            if (!ov) i_nxt = i_r + 1'b1;
            // uncovered pieces of the entry: top, left, right, bottom
            pc_nxt[0] = '{x1: p.x1, y1: p.y1, x2: p.x2, y2: n.y1};
            pc_nxt[1] = '{x1: p.x1, y1: y0,   x2: n.x1, y2: y1};
            pc_nxt[2] = '{x1: n.x2, y1: y0,   x2: p.x2, y2: y1};
            pc_nxt[3] = '{x1: p.x1, y1: n.y2, x2: p.x2, y2: p.y2};
            pm_nxt = {p.y2 > n.y2, p.x2 > n.x2, p.x1 < n.x1, p.y1 < n.y1};
          end
          drs_pkg::FUNC_CLIP: begin
            if (!clip_empty) begin
              t_we = 1'b1;
              t_wd = '{x1: ix1, y1: iy1, x2: ix2, y2: iy2};
              i_nxt = i_r + 1'b1;
            end
          end
          default: begin
            if (i_r == '0) begin
              acc_nxt = p;
            end else begin
              if (p.x1 < acc_r.x1) acc_nxt.x1 = p.x1;
              if (p.y1 < acc_r.y1) acc_nxt.y1 = p.y1;
              if (p.x2 > acc_r.x2) acc_nxt.x2 = p.x2;
              if (p.y2 > acc_r.y2) acc_nxt.y2 = p.y2;
            end
            hit_nxt = 1'b1;
            i_nxt = i_r + 1'b1;
          end
        endcase
      end
      drs_pkg::ST_DROP: begin
        // last entry moves into the hole
        cnt_nxt = cnt_r - 1'b1;
        t_re = 1'b1;
        t_ra = AW'(cnt_r - 1'b1);
      end
      drs_pkg::ST_MOVE: begin
        t_we = 1'b1;
        t_wd = t_rq;
      end
      drs_pkg::ST_APP: begin
        k_nxt = k_r + 1'b1;
        if (pm_r[k_r]) begin
          if (cnt_r < DEPTH_C) begin
            t_we = 1'b1;
            t_wa = cnt_r[AW-1:0];
            t_wd = pc_r[k_r];
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
      drs_pkg::ST_PUSH: begin
        k_nxt = k_r + 1'b1;
        if (pm_r[k_r]) begin
          if (sd_r < PDEPTH_C) begin
            p_we = 1'b1;
            sd_nxt = sd_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
      drs_pkg::ST_POP: begin
        if (sd_r != '0) begin
          sd_nxt = sd_r - 1'b1;
          p_re = 1'b1;
        end
      end
      drs_pkg::ST_POPD: begin
        n_nxt = p_rq.rect;
        i_nxt = p_rq.start;
      end
      drs_pkg::ST_RDW: begin
        acc_nxt = t_rq;
      end
      drs_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          dw = (CB + 1)'(acc_r.x2) - (CB + 1)'(acc_r.x1);
          dh = (CB + 1)'(acc_r.y2) - (CB + 1)'(acc_r.y1);
          out_valid_nxt = 1'b1;
          out_data_nxt.res_x = '0;
          out_data_nxt.res_y = '0;
          out_data_nxt.res_w = '0;
          out_data_nxt.res_h = '0;
          if (hit_r && (op_r == drs_pkg::FUNC_UNION || op_r == drs_pkg::FUNC_READ)) begin
            out_data_nxt.res_x = 16'(acc_r.x1);
            out_data_nxt.res_y = 16'(acc_r.y1);
            out_data_nxt.res_w = 16'($unsigned(dw));
            out_data_nxt.res_h = 16'($unsigned(dh));
          end
          out_data_nxt.count = cnt_w[6:0];
          if (ovf_r) out_data_nxt.status = drs_pkg::STATUS_OVF;
          else if (op_r == drs_pkg::FUNC_READ && !hit_r) begin
            out_data_nxt.status = drs_pkg::STATUS_RANGE;
          end else begin
            out_data_nxt.status = drs_pkg::STATUS_OK;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= drs_pkg::ST_IDLE;
      cnt_r       <= '0;
      sd_r        <= '0;
      out_valid_r <= 1'b0;
      ovf_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sd_r        <= sd_nxt;
      out_valid_r <= out_valid_nxt;
      ovf_r       <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    n_r        <= n_nxt;
    acc_r      <= acc_nxt;
    hit_r      <= hit_nxt;
    i_r        <= i_nxt;
    pc_r       <= pc_nxt;
    pm_r       <= pm_nxt;
    k_r        <= k_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C) else $error("entry count past table depth");
  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sd_r <= PDEPTH_C) else $error("pending stack past its depth");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall) else $error("second item taken while one is at work");
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == drs_pkg::ST_DONE))
    else $error("result shown outside the finish state");
`endif

endmodule
`default_nettype wire
